/* rtl/ssrq_pkg.sv */
// ssrq_pkg: shared constants for the slot scanning ring queue.
// Status codes, register index and parameter defaults; no dependencies.
`default_nettype none

package ssrq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // field widths fixed by the stream interface
    localparam int ELEM_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // register index (word address)
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

endpackage

`default_nettype wire

/* rtl/ssrq_ram.sv */
// ssrq_ram: generic simple dual-port RAM, one write and one read port.
// Read data registered, held while re is low. No dependencies.
`default_nettype none

module ssrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ssrq_scan.sv */
// ssrq_scan: rotating find-first over the occupancy vector.
// Finds the first slot at or after start (wrapping at n) whose bit equals want_full.
`default_nettype none

module ssrq_scan #(
    parameter int RING = 16,
    parameter int RW   = 4
) (
    input  wire logic [RING-1:0] occ,
    input  wire logic            want_full,
    input  wire logic [4:0]      n,
    input  wire logic [RW-1:0]   start,
    output logic                 found,
    output logic      [RW-1:0]   pos
);

    logic [RING-1:0] cand;
    logic [RING-1:0] upper;
    logic [RW-1:0]   st;
    logic [RW-1:0]   pos_up;
    logic [RW-1:0]   pos_all;

    // a pointer outside the ring restarts the scan at slot 0
    assign st = (int'(start) < int'(n)) ? start : '0;

    always_comb
    begin
        for (int i = 0; i < RING; i++)
        begin
            cand[i]  = (occ[i] == want_full) && (5'(i) < n);
            upper[i] = cand[i] && (RW'(i) >= st);
        end
    end

    always_comb
    begin
        pos_up  = '0;
        pos_all = '0;
        for (int i = RING - 1; i >= 0; i--)
        begin
            if (upper[i])
            begin
                pos_up = RW'(i);
            end
            if (cand[i])
            begin
                pos_all = RW'(i);
            end
        end
    end

    assign found = |cand;
    assign pos   = (|upper) ? pos_up : pos_all;

endmodule

`default_nettype wire

/* rtl/slot_scanning_ring_queue.sv */
// slot_scanning_ring_queue: ring of slots with occupancy scan, top level.
// Uses ssrq_pkg, ssrq_scan (find-first) and ssrq_ram (slot storage).
//
//  channel | beat signals          | content
//  s_*     | s_tvalid / s_tready   | tuser: action; tdata: element
//  m_*     | m_tvalid / m_tready   | tuser: status; tdata: element_out, occupancy, empty_res
//  apb     | psel/penable/pwrite   | slots_in_use at byte address 0
//
// One item per cycle sustained while m_tready is high; a beat passes the result stage
// and the output register before m_tvalid rises. The scan over the occupancy bits picks
// the slot in the beat cycle; the slot RAM read of a dequeue runs beside the result stage.
// Reset clears the occupancy bits, pointers and count; no RAM clearing pass.
// A stalled result holds; the input takes a beat only while the result stage is empty or moves out.
`default_nettype none

module slot_scanning_ring_queue #(
    parameter int DEPTH      = ssrq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ssrq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [31:0] element_out, [36:32] occupancy,
                                        // [37] empty_res, [39:38] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int RING    = (DEPTH < 31) ? DEPTH : 31;
    localparam int RW      = $clog2(RING);
    localparam int AW      = $clog2(DEPTH);
    localparam int EW      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int SIU_RST = (DEPTH < 16) ? DEPTH : 16;

    // configuration
    logic [4:0] siu_reg;
    logic [4:0] siu_next;
    logic [4:0] wval;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == ssrq_pkg::REG_SLOTS_IN_USE);
    assign wval   = pwdata[4:0];

    always_comb
    begin
        priority if (wval == 5'd0)
        begin
            siu_next = 5'd1;
        end
        else if (int'(wval) > RING)
        begin
            siu_next = 5'(RING);
        end
        else
        begin
            siu_next = wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg <= 5'(SIU_RST);
        end
        else if (cfg_wr)
        begin
            siu_reg <= siu_next;
        end
    end

    assign prdata = (paddr[2] == ssrq_pkg::REG_SLOTS_IN_USE) ? {27'd0, siu_reg} : 32'd0;

    // queue state
    logic [RING-1:0]                  occ_reg;
    logic [RING-1:0]                  occ_next;
    logic [RW-1:0]                    wptr_reg;
    logic [RW-1:0]                    rptr_reg;
    logic [ssrq_pkg::COUNT_W-1:0]     count_reg;
    logic [ssrq_pkg::COUNT_W-1:0]     count_next;

    // result stage waiting on the RAM read
    logic                             p1_valid_reg;
    logic [ssrq_pkg::STATUS_W-1:0]    p1_status_reg;
    logic                             p1_take_reg;
    logic [ssrq_pkg::COUNT_W-1:0]     p1_count_reg;

    // output register
    logic                             m_valid_reg;
    logic [ssrq_pkg::STATUS_W-1:0]    m_status_reg;
    logic [ssrq_pkg::ELEM_W-1:0]      m_elem_reg;
    logic [ssrq_pkg::COUNT_W-1:0]     m_count_reg;

    logic                             acc;
    logic                             out_load;
    logic                             action;
    logic                             nz;
    logic [DATA_WIDTH-1:0]            elem;
    logic                             w_found;
    logic [RW-1:0]                    w_pos;
    logic                             r_found;
    logic [RW-1:0]                    r_pos;
    logic                             enq_ok;
    logic                             deq_ok;
    logic [ssrq_pkg::STATUS_W-1:0]    status;
    logic [DATA_WIDTH-1:0]            rdata;

    assign out_load = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || out_load;
    assign acc      = s_tvalid && s_tready;

    assign action = s_tuser[0];
    assign nz     = |s_tdata[EW-1:0];
    assign elem   = DATA_WIDTH'(s_tdata[EW-1:0]);

    ssrq_scan #(.RING(RING), .RW(RW)) u_wscan (
        .occ       (occ_reg),
        .want_full (1'b0),
        .n         (siu_reg),
        .start     (wptr_reg),
        .found     (w_found),
        .pos       (w_pos)
    );

    ssrq_scan #(.RING(RING), .RW(RW)) u_rscan (
        .occ       (occ_reg),
        .want_full (1'b1),
        .n         (siu_reg),
        .start     (rptr_reg),
        .found     (r_found),
        .pos       (r_pos)
    );

    assign enq_ok = !action && nz && w_found;
    assign deq_ok = action && r_found;

    always_comb
    begin
        priority if (action)
        begin
            status = r_found ? ssrq_pkg::ST_OK : ssrq_pkg::ST_EMPTY;
        end
        else if (!nz)
        begin
            status = ssrq_pkg::ST_ZERO;
        end
        else
        begin
            status = w_found ? ssrq_pkg::ST_OK : ssrq_pkg::ST_FULL;
        end
    end

    always_comb
    begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (enq_ok)
        begin
            occ_next[w_pos] = 1'b1;
            count_next      = count_reg + 5'd1;
        end
        if (deq_ok)
        begin
            occ_next[r_pos] = 1'b0;
            count_next      = count_reg - 5'd1;
        end
    end

    ssrq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_slots (
        .clk   (clk),
        .we    (acc && enq_ok),
        .waddr (AW'(w_pos)),
        .wdata (elem),
        .re    (acc && deq_ok),
        .raddr (AW'(r_pos)),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else if (acc)
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
            if (enq_ok)
            begin
                wptr_reg <= w_pos;
            end
            if (deq_ok)
            begin
                rptr_reg <= r_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p1_status_reg <= status;
            p1_take_reg   <= deq_ok;
            p1_count_reg  <= count_next;
        end
        // RAM output holds until the next dequeue beat, which waits for this load
        if (out_load)
        begin
            m_status_reg <= p1_status_reg;
            m_elem_reg   <= p1_take_reg ? 32'(rdata[EW-1:0]) : 32'd0;
            m_count_reg  <= p1_count_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, (m_count_reg == 5'd0), m_count_reg, m_elem_reg};

endmodule

`default_nettype wire

/* rtl/ssrq_chk.sv */
// ssrq_chk: port-level checker for slot_scanning_ring_queue, bound to the top.
// Uses ssrq_pkg status codes.
`default_nettype none

module ssrq_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // empty flag follows the occupancy field
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[37] == (m_tdata[36:32] == 5'd0)))
        else $error("empty_res disagrees with occupancy");

    // only a successful beat carries a dequeued element
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ssrq_pkg::ST_OK)) |-> (m_tdata[31:0] == 32'd0))
        else $error("element_out nonzero on a refused beat");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output free");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind slot_scanning_ring_queue ssrq_chk u_ssrq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
